// ----- hw/rtl/nonuniform_simpson_integrator_defines.svh -----
// Assertion macros used by the integrator top level.
`ifndef NONUNIFORM_SIMPSON_INTEGRATOR_DEFINES_SVH
`define NONUNIFORM_SIMPSON_INTEGRATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define NSI_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nsi: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define NSI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nsi: next-cycle check failed");

`endif

// ----- hw/rtl/nsi_pkg.sv -----
`default_nettype none
package nsi_pkg;

    localparam int FRAC_BITS = 16;
    localparam logic signed [63:0] TWO_FX    = 64'sd2 <<< FRAC_BITS;
    localparam logic signed [63:0] INT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] INT64_MIN = 64'sh8000_0000_0000_0000;

    // ceil(2^65 / 6): magnitudes up to 2^63 divide by six exactly after a 65-bit shift
    localparam logic signed [63:0] RECIP6       = 64'sh5555_5555_5555_5556;
    localparam int                 RECIP6_SHIFT = 65;

    // Command kinds passed from front to back
    localparam logic [1:0] CMD_CLOSE = 2'd0;
    localparam logic [1:0] CMD_PANEL = 2'd1;
    localparam logic [1:0] CMD_TRAP  = 2'd2;

    // Product scaling codes for the multiplier
    localparam logic [1:0] SH_NONE = 2'd0;
    localparam logic [1:0] SH_ONE  = 2'd1;
    localparam logic [1:0] SH_FRAC = 2'd2;
    localparam logic [1:0] SH_DIV6 = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic               last;
        logic signed [32:0] h0;
        logic signed [32:0] h1;
        logic signed [31:0] y0;
        logic signed [31:0] y1;
        logic signed [31:0] y2;
    } t_cmd;

    function automatic logic [63:0] mag(input logic [63:0] v);
        mag = v[63] ? (64'd0 - v) : v;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/nsi_front.sv -----
`default_nettype none
module nsi_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_x_coord,
    input  logic signed [31:0] i_y_value,
    input  logic               i_last_sample,
    output logic               o_cmd_valid,
    output nsi_pkg::t_cmd      o_cmd,
    input  logic               i_cmd_pop
);

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [1:0] PH_EMPTY = 2'd0;
    localparam logic [1:0] PH_ONE   = 2'd1;
    localparam logic [1:0] PH_TWO   = 2'd2;

    logic [1:0]         r_phase, n_phase;
    logic signed [31:0] r_older_x, r_older_y, r_newer_x, r_newer_y;
    nsi_pkg::t_cmd      r_queue [QDEPTH];
    logic [QAW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [QAW:0]       r_count;
    logic               w_accept, w_push;
    nsi_pkg::t_cmd      w_cmd;
    logic signed [32:0] w_h_new, w_h_old;

    assign w_accept    = i_valid && o_ready;
    assign o_ready     = (r_count != (QAW+1)'(QDEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_queue[r_rd_ptr];

    assign w_h_new = 33'(i_x_coord) - 33'(r_newer_x);
    assign w_h_old = 33'(r_newer_x) - 33'(r_older_x);

    always_comb begin
        w_cmd.kind = nsi_pkg::CMD_CLOSE;
        w_cmd.last = i_last_sample;
        w_cmd.h0   = w_h_new;
        w_cmd.h1   = w_h_new;
        w_cmd.y0   = r_newer_y;
        w_cmd.y1   = i_y_value;
        w_cmd.y2   = i_y_value;
        w_push     = i_last_sample;
        n_phase    = PH_ONE;
        unique case (r_phase)
            PH_TWO: begin
                w_cmd.kind = nsi_pkg::CMD_PANEL;
                w_cmd.h0   = w_h_old;
                w_cmd.y0   = r_older_y;
                w_cmd.y1   = r_newer_y;
                w_push     = 1'b1;
                n_phase    = PH_ONE;
            end
            PH_ONE: begin
                w_cmd.kind = nsi_pkg::CMD_TRAP;
                n_phase    = PH_TWO;
            end
            default: begin
                n_phase = PH_ONE;
            end
        endcase
        // last sample closes the run
        if (i_last_sample) begin
            n_phase = PH_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_EMPTY;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_accept) begin
                r_phase <= n_phase;
            end
            if (w_accept && w_push) begin
                r_wr_ptr <= r_wr_ptr + QAW'(1);
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            r_count <= r_count + (QAW+1)'(w_accept && w_push) - (QAW+1)'(i_cmd_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_newer_x <= i_x_coord;
            r_newer_y <= i_y_value;
            if (r_phase == PH_ONE) begin
                r_older_x <= r_newer_x;
                r_older_y <= r_newer_y;
            end
        end
        if (w_accept && w_push) begin
            r_queue[r_wr_ptr] <= w_cmd;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/nsi_div.sv -----
`default_nettype none
module nsi_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_dividend,
    input  logic signed [63:0] i_divisor,
    output logic               o_done,
    output logic signed [63:0] o_quotient
);

    localparam logic [6:0] LAST_STEP = 7'd64;

    logic [63:0]        r_rem, r_quo, r_den;
    logic               r_neg, r_busy, r_done;
    logic [6:0]         r_cnt;
    logic signed [63:0] r_res;
    logic [64:0]        w_trial;

    assign w_trial    = {r_rem, r_quo[63]} - {1'b0, r_den};
    assign o_done     = r_done;
    assign o_quotient = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy && r_cnt == LAST_STEP) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
            end
        end
    end

    // restoring division on magnitudes, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= nsi_pkg::mag(i_dividend);
            r_den <= nsi_pkg::mag(i_divisor);
            r_neg <= i_dividend[63] ^ i_divisor[63];
        end else if (r_busy && r_cnt != LAST_STEP) begin
            if (!w_trial[64]) begin
                r_rem <= w_trial[63:0];
                r_quo <= {r_quo[62:0], 1'b1};
            end else begin
                r_rem <= {r_rem[62:0], r_quo[63]};
                r_quo <= {r_quo[62:0], 1'b0};
            end
        end else if (r_busy) begin
            r_res <= r_neg ? (64'd0 - r_quo) : r_quo;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/nsi_mul.sv -----
`default_nettype none
module nsi_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    input  logic [1:0]         i_shift,
    output logic               o_done,
    output logic signed [63:0] o_product,
    output logic               o_overflow
);

    localparam logic [2:0] PP_STEPS = 3'd4;
    localparam logic [2:0] FIN_STEP = 3'd5;

    logic [63:0]        r_ua, r_ub, r_pp;
    logic               r_neg, r_busy, r_done, r_ovf;
    logic [1:0]         r_sh, r_off;
    logic [127:0]       r_acc;
    logic [2:0]         r_cnt;
    logic signed [63:0] r_res;
    logic [31:0]        w_ah, w_bh;
    logic [1:0]         w_off;
    logic [127:0]       w_pp_pos, w_shifted;
    logic [63:0]        w_hi, w_lo, w_limit;

    assign o_done     = r_done;
    assign o_product  = r_res;
    assign o_overflow = r_ovf;

    always_comb begin
        w_ah  = r_cnt[0] ? r_ua[63:32] : r_ua[31:0];
        w_bh  = r_cnt[1] ? r_ub[63:32] : r_ub[31:0];
        w_off = {1'b0, r_cnt[0]} + {1'b0, r_cnt[1]};
        unique case (r_off)
            2'd1:    w_pp_pos = {32'd0, r_pp, 32'd0};
            2'd2:    w_pp_pos = {r_pp, 64'd0};
            default: w_pp_pos = {64'd0, r_pp};
        endcase
        unique case (r_sh)
            nsi_pkg::SH_ONE:  w_shifted = r_acc >> 1;
            nsi_pkg::SH_FRAC: w_shifted = r_acc >> nsi_pkg::FRAC_BITS;
            nsi_pkg::SH_DIV6: w_shifted = r_acc >> nsi_pkg::RECIP6_SHIFT;
            default:          w_shifted = r_acc;
        endcase
        w_hi    = w_shifted[127:64];
        w_lo    = w_shifted[63:0];
        w_limit = r_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy && r_cnt == FIN_STEP) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end

    // four 32x32 partial products, each registered in r_pp and added to the accumulator in the next cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ua  <= nsi_pkg::mag(i_a);
            r_ub  <= nsi_pkg::mag(i_b);
            r_neg <= i_a[63] ^ i_b[63];
            r_sh  <= i_shift;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_cnt < PP_STEPS) begin
                r_pp  <= w_ah * w_bh;
                r_off <= w_off;
            end
            if (r_cnt != '0 && r_cnt <= PP_STEPS) begin
                r_acc <= r_acc + w_pp_pos;
            end
            if (r_cnt == FIN_STEP) begin
                if (w_hi != '0 || w_lo > w_limit) begin
                    r_ovf <= 1'b1;
                    r_res <= r_neg ? nsi_pkg::INT64_MIN : nsi_pkg::INT64_MAX;
                end else begin
                    r_ovf <= 1'b0;
                    r_res <= r_neg ? (64'd0 - w_lo) : w_lo;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/nsi_back.sv -----
`default_nettype none
module nsi_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  nsi_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [63:0] o_area,
    output logic               o_spacing_error,
    output logic               o_saturated
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_R10  = 4'd1;
    localparam logic [3:0] ST_R01  = 4'd2;
    localparam logic [3:0] ST_Q0   = 4'd3;
    localparam logic [3:0] ST_Q1   = 4'd4;
    localparam logic [3:0] ST_WB   = 4'd5;
    localparam logic [3:0] ST_BA   = 4'd6;
    localparam logic [3:0] ST_BB   = 4'd7;
    localparam logic [3:0] ST_BC   = 4'd8;
    localparam logic [3:0] ST_BS   = 4'd9;
    localparam logic [3:0] ST_D6   = 4'd10;
    localparam logic [3:0] ST_TRAP = 4'd11;
    localparam logic [3:0] ST_ACC  = 4'd12;
    localparam logic [3:0] ST_DONE = 4'd13;

    logic [3:0]         r_state;
    logic               r_wait;
    nsi_pkg::t_cmd      r_cmd;
    logic signed [33:0] r_s;
    logic signed [63:0] r_wa, r_wc, r_q0, r_q1, r_wb, r_br, r_t, r_sum;
    logic               r_err, r_ovf;
    logic               r_out_valid, r_out_err, r_out_sat;
    logic signed [63:0] r_area;

    logic               w_div_start, w_div_done;
    logic signed [63:0] w_div_num, w_div_den, w_div_q;
    logic               w_mul_start, w_mul_done, w_mul_ovf;
    logic signed [63:0] w_mul_a, w_mul_b, w_mul_res;
    logic [1:0]         w_mul_sh;
    logic signed [32:0] w_ysum;
    logic [64:0]        w_add_br, w_add_sum;

    function automatic logic [64:0] sat_add(input logic signed [63:0] a,
                                            input logic signed [63:0] b);
        logic signed [64:0] sum;
        sum = 65'(a) + 65'(b);
        if (sum[64] != sum[63]) begin
            sat_add = {1'b1, a[63] ? nsi_pkg::INT64_MIN : nsi_pkg::INT64_MAX};
        end else begin
            sat_add = {1'b0, sum[63:0]};
        end
    endfunction

    assign o_cmd_pop       = (r_state == ST_IDLE) && i_cmd_valid;
    assign o_valid         = r_out_valid;
    assign o_area          = r_area;
    assign o_spacing_error = r_out_err;
    assign o_saturated     = r_out_sat;

    assign w_ysum    = 33'($signed(r_cmd.y0)) + 33'($signed(r_cmd.y1));
    assign w_add_br  = sat_add(r_br, w_mul_res);
    assign w_add_sum = sat_add(r_sum, r_t);

    always_comb begin
        w_div_start = 1'b0;
        w_mul_start = 1'b0;
        w_div_num   = 64'($signed(r_cmd.h1)) <<< nsi_pkg::FRAC_BITS;
        w_div_den   = 64'($signed(r_cmd.h0));
        w_mul_a     = r_q0;
        w_mul_b     = r_q1;
        w_mul_sh    = nsi_pkg::SH_FRAC;
        unique case (r_state)
            ST_R10: begin
                w_div_start = !r_wait;
            end
            ST_R01: begin
                w_div_start = !r_wait;
                w_div_num   = 64'($signed(r_cmd.h0)) <<< nsi_pkg::FRAC_BITS;
                w_div_den   = 64'($signed(r_cmd.h1));
            end
            ST_Q0: begin
                w_div_start = !r_wait;
                w_div_num   = 64'(r_s) <<< nsi_pkg::FRAC_BITS;
            end
            ST_Q1: begin
                w_div_start = !r_wait;
                w_div_num   = 64'(r_s) <<< nsi_pkg::FRAC_BITS;
                w_div_den   = 64'($signed(r_cmd.h1));
            end
            ST_D6: begin
                // divide by six through the reciprocal, truncating the magnitude
                w_mul_start = !r_wait;
                w_mul_a     = r_t;
                w_mul_b     = nsi_pkg::RECIP6;
                w_mul_sh    = nsi_pkg::SH_DIV6;
            end
            ST_WB: begin
                w_mul_start = !r_wait;
            end
            ST_BA: begin
                w_mul_start = !r_wait;
                w_mul_a     = r_wa;
                w_mul_b     = 64'($signed(r_cmd.y0));
                w_mul_sh    = nsi_pkg::SH_NONE;
            end
            ST_BB: begin
                w_mul_start = !r_wait;
                w_mul_a     = r_wb;
                w_mul_b     = 64'($signed(r_cmd.y1));
                w_mul_sh    = nsi_pkg::SH_NONE;
            end
            ST_BC: begin
                w_mul_start = !r_wait;
                w_mul_a     = r_wc;
                w_mul_b     = 64'($signed(r_cmd.y2));
                w_mul_sh    = nsi_pkg::SH_NONE;
            end
            ST_BS: begin
                w_mul_start = !r_wait;
                w_mul_a     = r_br;
                w_mul_b     = 64'(r_s);
            end
            ST_TRAP: begin
                w_mul_start = !r_wait;
                w_mul_a     = 64'($signed(r_cmd.h0));
                w_mul_b     = 64'(w_ysum);
                w_mul_sh    = nsi_pkg::SH_ONE;
            end
            default: begin
            end
        endcase
    end

    nsi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_num),
        .i_divisor  (w_div_den),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    nsi_mul u_mul (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mul_start),
        .i_a        (w_mul_a),
        .i_b        (w_mul_b),
        .i_shift    (w_mul_sh),
        .o_done     (w_mul_done),
        .o_product  (w_mul_res),
        .o_overflow (w_mul_ovf)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wait      <= 1'b0;
            r_out_valid <= 1'b0;
            r_sum       <= '0;
            r_err       <= 1'b0;
            r_ovf       <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_div_start || w_mul_start) begin
                r_wait <= 1'b1;
            end
            if (w_div_done || w_mul_done) begin
                r_wait <= 1'b0;
            end
            if (w_mul_done) begin
                r_ovf <= r_ovf | w_mul_ovf;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        r_s   <= 34'($signed(i_cmd.h0)) + 34'($signed(i_cmd.h1));
                        priority if (i_cmd.kind == nsi_pkg::CMD_PANEL) begin
                            // zero spacing: flag and skip the panel
                            if (i_cmd.h0 == '0 || i_cmd.h1 == '0) begin
                                r_err   <= 1'b1;
                                r_state <= ST_DONE;
                            end else begin
                                r_state <= ST_R10;
                            end
                        end else if (i_cmd.kind == nsi_pkg::CMD_TRAP) begin
                            r_state <= ST_TRAP;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_R10: if (w_div_done) begin
                    r_wa    <= nsi_pkg::TWO_FX - w_div_q;
                    r_state <= ST_R01;
                end
                ST_R01: if (w_div_done) begin
                    r_wc    <= nsi_pkg::TWO_FX - w_div_q;
                    r_state <= ST_Q0;
                end
                ST_Q0: if (w_div_done) begin
                    r_q0    <= w_div_q;
                    r_state <= ST_Q1;
                end
                ST_Q1: if (w_div_done) begin
                    r_q1    <= w_div_q;
                    r_state <= ST_WB;
                end
                ST_WB: if (w_mul_done) begin
                    r_wb    <= w_mul_res;
                    r_state <= ST_BA;
                end
                ST_BA: if (w_mul_done) begin
                    r_br    <= w_mul_res;
                    r_state <= ST_BB;
                end
                ST_BB: if (w_mul_done) begin
                    r_br    <= w_add_br[63:0];
                    r_ovf   <= r_ovf | w_mul_ovf | w_add_br[64];
                    r_state <= ST_BC;
                end
                ST_BC: if (w_mul_done) begin
                    r_br    <= w_add_br[63:0];
                    r_ovf   <= r_ovf | w_mul_ovf | w_add_br[64];
                    r_state <= ST_BS;
                end
                ST_BS: if (w_mul_done) begin
                    r_t     <= w_mul_res;
                    r_state <= ST_D6;
                end
                ST_D6: if (w_mul_done) begin
                    r_t     <= w_mul_res;
                    r_state <= ST_ACC;
                end
                ST_TRAP: if (w_mul_done) begin
                    r_t     <= w_mul_res;
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    r_sum   <= w_add_sum[63:0];
                    r_ovf   <= r_ovf | w_add_sum[64];
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_cmd.last) begin
                        r_state <= ST_IDLE;
                    end else if (!r_out_valid || i_ready) begin
                        // hand out the run result and clear the run
                        r_out_valid <= 1'b1;
                        r_area      <= r_sum;
                        r_out_err   <= r_err;
                        r_out_sat   <= r_ovf;
                        r_sum       <= '0;
                        r_err       <= 1'b0;
                        r_ovf       <= 1'b0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/nonuniform_simpson_integrator.sv -----
// Result path: a closing sample that ends a Simpson panel gives its result after four passes
// of the radix-2 divider and six multiplies; a closing trapezoid after one multiply, and a
// lone sample goes straight to the output stage.
// Throughput: one panel per two samples; the back end finishes one command before popping the next.
// Samples enter at one per cycle while the two-entry command queue has room.
// Reset (synchronous, active low) empties the queue, drops the run and any pending result.
`default_nettype none
`include "nonuniform_simpson_integrator_defines.svh"
module nonuniform_simpson_integrator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_x_coord,
    input  logic signed [31:0] i_y_value,
    input  logic               i_last_sample,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [63:0] o_area,
    output logic               o_spacing_error,
    output logic               o_saturated
);

    logic          w_cmd_valid, w_cmd_pop;
    nsi_pkg::t_cmd w_cmd;

    nsi_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_x_coord     (i_x_coord),
        .i_y_value     (i_y_value),
        .i_last_sample (i_last_sample),
        .o_cmd_valid   (w_cmd_valid),
        .o_cmd         (w_cmd),
        .i_cmd_pop     (w_cmd_pop)
    );

    nsi_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (w_cmd_valid),
        .i_cmd           (w_cmd),
        .o_cmd_pop       (w_cmd_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_area          (o_area),
        .o_spacing_error (o_spacing_error),
        .o_saturated     (o_saturated)
    );

    `NSI_ASSERT_NOW(a_pop_needs_cmd, w_cmd_pop, w_cmd_valid)
    `NSI_ASSERT_NOW(a_empty_has_room, !w_cmd_valid, o_ready)
    `NSI_ASSERT_NEXT(a_no_double_pop, w_cmd_pop, !w_cmd_pop)

endmodule
`default_nettype wire
